### hdl/pcbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcbl_pkg;

	// Default number of client buckets in the table.
	localparam int TABLE_ENTRIES_DEF = 16;

	// Field widths.
	localparam int ADDR_W  = 32;
	localparam int TIME_W  = 32;
	localparam int TOK_W   = 10;
	localparam int CFG_W   = 10;
	localparam int PROD_W  = TIME_W + CFG_W;
	localparam int SUM_W   = PROD_W + 1;

	// One table word: {time, tokens, address}, address in the lowest bits.
	localparam int WORD_W  = ADDR_W + TOK_W + TIME_W;

	// Stream word widths.
	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 16;

	// Register indexes on the configuration port.
	localparam logic REG_BURST = 1'b0;
	localparam logic REG_RATE  = 1'b1;

	// Register reset values.
	localparam logic [CFG_W-1:0] BURST_RST = 10'd20;
	localparam logic [CFG_W-1:0] RATE_RST  = 10'd10;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the request word and clear the search flags
		logic scan;    // table search is running; read one entry per cycle
		logic pick;    // choose the slot and work out elapsed time and base tokens
		logic mul;     // multiply elapsed time by the refill rate
		logic finish;  // clamp, grant, write the slot back and load the output
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic match;     // the entry compared this cycle holds the request address
		logic last;      // the entry compared this cycle is the last slot
		logic out_busy;  // the output register holds a word that is not taken
	} sts_t;

endpackage

`default_nettype wire

### hdl/pcbl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module pcbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hdl/pcbl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Request sequencer: accepts a word, walks the table, then steps the
// arithmetic and write-back.
module pcbl_ctrl #(
	parameter int TABLE_ENTRIES = pcbl_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire pcbl_pkg::sts_t                   sts,
	output pcbl_pkg::cmd_t                        cmd,
	output logic [$clog2(TABLE_ENTRIES)-1:0]      rd_addr
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_PICK = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t        state_q;
	state_t        state_d;
	logic [IW-1:0] cnt_q;
	logic          accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.match || sts.last) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Read address for the table search; it holds at the last slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == ST_SCAN && cnt_q != LAST_IDX) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign rd_addr = cnt_q;

	// Commands to the datapath.
	always_comb begin
		cmd.load   = accept;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.pick   = (state_q == ST_PICK);
		cmd.mul    = (state_q == ST_MUL);
		cmd.finish = (state_q == ST_FIN) && !sts.out_busy;
	end

	// A new word always starts a search.
	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SCAN)
		else $error("search did not start after an accepted word");

	// A hit ends the search at once.
	a_match_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && sts.match |=> state_q == ST_PICK)
		else $error("search went on after a hit");

	// A finished request returns the sequencer to idle.
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after write-back");

endmodule

`default_nettype wire

### hdl/pcbl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

// Bucket datapath: table storage, search compare, refill arithmetic,
// configuration registers and the output register.
module pcbl_dp #(
	parameter int TABLE_ENTRIES = pcbl_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire pcbl_pkg::cmd_t                        cmd,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0]      rd_addr,
	output pcbl_pkg::sts_t                             sts,
	input  wire logic [pcbl_pkg::ADDR_W-1:0]           req_addr,
	input  wire logic [pcbl_pkg::TIME_W-1:0]           req_now,
	input  wire logic                                  cfg_we,
	input  wire logic                                  cfg_idx,
	input  wire logic [pcbl_pkg::CFG_W-1:0]            cfg_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       out_granted,
	output logic [pcbl_pkg::TOK_W-1:0]                 out_left
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

	// Configuration registers.
	logic [pcbl_pkg::CFG_W-1:0] burst_q;
	logic [pcbl_pkg::CFG_W-1:0] rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q <= pcbl_pkg::BURST_RST;
			rate_q  <= pcbl_pkg::RATE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				pcbl_pkg::REG_BURST: burst_q <= cfg_data;
				pcbl_pkg::REG_RATE:  rate_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Request capture.
	logic [pcbl_pkg::ADDR_W-1:0] req_addr_q;
	logic [pcbl_pkg::TIME_W-1:0] req_now_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_addr_q <= req_addr;
			req_now_q  <= req_now;
		end
	end

	// Table storage and per-slot valid bits.
	logic [TABLE_ENTRIES-1:0]      valid_q;
	logic [pcbl_pkg::WORD_W-1:0]   rd_data;
	logic [pcbl_pkg::WORD_W-1:0]   wr_data;
	logic [IW-1:0]                 slot_q;

	pcbl_ram #(
		.WIDTH (pcbl_pkg::WORD_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (cmd.finish),
		.waddr (slot_q),
		.wdata (wr_data),
		.re    (cmd.scan),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	logic [pcbl_pkg::ADDR_W-1:0] rd_addr_f;
	logic [pcbl_pkg::TOK_W-1:0]  rd_tok_f;
	logic [pcbl_pkg::TIME_W-1:0] rd_time_f;

	assign rd_addr_f = rd_data[pcbl_pkg::ADDR_W-1:0];
	assign rd_tok_f  = rd_data[pcbl_pkg::ADDR_W +: pcbl_pkg::TOK_W];
	assign rd_time_f = rd_data[pcbl_pkg::ADDR_W + pcbl_pkg::TOK_W +: pcbl_pkg::TIME_W];

	// Compare stage: the read data belongs to the index issued in the previous cycle.
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          cmp_on;
	logic          cmp_slot_valid;
	logic          cmp_match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_addr;
	end

	assign cmp_on         = cmp_vld_s1 && cmd.scan;
	assign cmp_slot_valid = valid_q[cmp_idx_s1];
	assign cmp_match      = cmp_on && cmp_slot_valid && (rd_addr_f == req_addr_q);

	assign sts.match    = cmp_match;
	assign sts.last     = cmp_on && (cmp_idx_s1 == LAST_IDX);

	// Search results: the hit entry and the lowest free slot.
	logic                        hit_q;
	logic [IW-1:0]               hit_idx_q;
	logic [pcbl_pkg::TOK_W-1:0]  hit_tok_q;
	logic [pcbl_pkg::TIME_W-1:0] hit_time_q;
	logic                        free_q;
	logic [IW-1:0]               free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (cmp_match) begin
				hit_q <= 1'b1;
			end
			if (cmp_on && !cmp_slot_valid) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_match) begin
			hit_idx_q  <= cmp_idx_s1;
			hit_tok_q  <= rd_tok_f;
			hit_time_q <= rd_time_f;
		end
		if (cmp_on && !cmp_slot_valid && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// Slot choice; a full table replaces slots in round-robin order.
	logic [IW-1:0]               ptr_q;
	logic [pcbl_pkg::TIME_W-1:0] elapsed_q;
	logic [pcbl_pkg::TOK_W-1:0]  base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.pick && !hit_q && !free_q) begin
			ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
		end
	end

	// A new client starts full with no time elapsed; time going back counts as zero.
	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			if (hit_q) begin
				slot_q    <= hit_idx_q;
				base_q    <= hit_tok_q;
				elapsed_q <= (req_now_q >= hit_time_q) ? req_now_q - hit_time_q : '0;
			end else begin
				slot_q    <= free_q ? free_idx_q : ptr_q;
				base_q    <= burst_q;
				elapsed_q <= '0;
			end
		end
	end

	// Refill amount.
	logic [pcbl_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= pcbl_pkg::PROD_W'(elapsed_q) * pcbl_pkg::PROD_W'(rate_q);
		end
	end

	// Clamp to the burst limit, then spend one token if there is one.
	logic [pcbl_pkg::SUM_W-1:0] sum_w;
	logic [pcbl_pkg::TOK_W-1:0] tok_w;
	logic                       grant_w;
	logic [pcbl_pkg::TOK_W-1:0] left_w;

	always_comb begin
		sum_w   = pcbl_pkg::SUM_W'(prod_q) + pcbl_pkg::SUM_W'(base_q);
		tok_w   = (sum_w > pcbl_pkg::SUM_W'(burst_q)) ? burst_q : sum_w[pcbl_pkg::TOK_W-1:0];
		grant_w = (tok_w != '0);
		left_w  = grant_w ? tok_w - 1'b1 : '0;
	end

	assign wr_data = {req_now_q, left_w, req_addr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.finish) begin
			valid_q[slot_q] <= 1'b1;
		end
	end

	// Output register.
	logic                       out_valid_q;
	logic                       out_granted_q;
	logic [pcbl_pkg::TOK_W-1:0] out_left_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_granted_q <= grant_w;
			out_left_q    <= left_w;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_granted  = out_granted_q;
	assign out_left     = out_left_q;

	// Every write-back produces an output word.
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q && valid_q[slot_q])
		else $error("write-back without output word or slot valid bit");

	// A refused request reports no tokens.
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_granted_q |-> out_left_q == '0)
		else $error("refused request reports tokens");

	// A granted request leaves fewer tokens than the burst limit.
	a_grant_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && grant_w |-> left_w < burst_q)
		else $error("remaining tokens not below burst limit");

endmodule

`default_nettype wire

### hdl/per_client_token_bucket_limiter.sv
`timescale 1ns / 1ps
`default_nettype none

// Per-client token bucket rate limiter. Each request word carries a client
// IPv4 address and the current time in seconds; the block answers with one
// word holding a grant flag and the whole tokens left in that client's bucket.
// Buckets live in a table of TABLE_ENTRIES slots; a new client takes the
// lowest free slot with a full bucket, and once the table is full slots are
// replaced in round-robin order. The search reads the table one slot per
// clock through a single RAM read port until it finds the client or
// reaches the last slot; after it the slot choice with the elapsed time,
// the refill multiply, and the clamp with the write-back follow in turn,
// and the write-back waits while the output register holds an untaken
// answer. A new request is accepted while the previous answer still waits
// in the output register. No clearing pass is needed after reset. Write
// burst_limit and refill_rate only while no request is in flight.
module per_client_token_bucket_limiter #(
	parameter int TABLE_ENTRIES = pcbl_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Request stream.
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [pcbl_pkg::S_DATA_W-1:0]   s_tdata,  // [31:0] client_ip, [63:32] now_seconds
	// Answer stream.
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [pcbl_pkg::M_DATA_W-1:0]        m_tdata,  // [0] granted, [10:1] tokens_left, zero above
	// Configuration writes: index 0 burst_limit, index 1 refill_rate.
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_idx,
	input  wire logic [pcbl_pkg::CFG_W-1:0]      cfg_data
);

	pcbl_pkg::cmd_t                    cmd;
	pcbl_pkg::sts_t                    sts;
	logic [$clog2(TABLE_ENTRIES)-1:0]  rd_addr;
	logic                              out_granted;
	logic [pcbl_pkg::TOK_W-1:0]        out_left;

	pcbl_ctrl #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	pcbl_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.sts         (sts),
		.req_addr    (s_tdata[pcbl_pkg::ADDR_W-1:0]),
		.req_now     (s_tdata[pcbl_pkg::ADDR_W +: pcbl_pkg::TIME_W]),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_granted (out_granted),
		.out_left    (out_left)
	);

	// Pack the answer word.
	assign m_tdata = {{(pcbl_pkg::M_DATA_W - pcbl_pkg::TOK_W - 1){1'b0}}, out_left, out_granted};

endmodule

`default_nettype wire
